// ----- hdl/afld_pkg.sv -----
// Shared types, constants and the dB threshold table of the frame level meter.
`default_nettype none

package afld_pkg;

   // Accumulator and counter sizes for frames of up to MAX_SAMPLES samples.
   localparam int MAX_SAMPLES = 4096;
   localparam int SUM_W       = 28;
   localparam int CNT_W       = 13;
   localparam int MAG_W       = 17;

   // Threshold search range and arithmetic widths.
   localparam int TOP_STEP    = 96;
   localparam int STEP_W      = 7;
   localparam int THR_W       = 33;
   localparam int FRAC_W      = 16;
   localparam int PROD_W      = CNT_W + THR_W;
   localparam int LEVEL_W     = 8;

   // Depth of the queue between the accumulator and the level search.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QFILL_W     = 2;

   // One finished frame handed from the front to the back.
   typedef struct packed {
      logic [SUM_W-1:0] abs_sum;
      logic [CNT_W-1:0] sample_count;
   } frame_type;

   typedef logic [THR_W-1:0] thr_tab_type [0:TOP_STEP];

   // Builds 10^(k/20) in Q17.16 from twenty mantissas scaled by 10^12, rounded to nearest.
   function automatic thr_tab_type build_thr_tab();
      thr_tab_type tab;
      logic [63:0] root;
      logic [63:0] num;
      logic [63:0] quo;
      int          r;
      int          q;
      for (int k = 0; k <= TOP_STEP; k++) begin
         r = k % 20;
         q = (k / 20) % 5;
         case (r)
            0:       root = 64'd1000000000000;
            1:       root = 64'd1122018454302;
            2:       root = 64'd1258925411794;
            3:       root = 64'd1412537544623;
            4:       root = 64'd1584893192461;
            5:       root = 64'd1778279410039;
            6:       root = 64'd1995262314969;
            7:       root = 64'd2238721138568;
            8:       root = 64'd2511886431510;
            9:       root = 64'd2818382931264;
            10:      root = 64'd3162277660168;
            11:      root = 64'd3548133892336;
            12:      root = 64'd3981071705535;
            13:      root = 64'd4466835921510;
            14:      root = 64'd5011872336273;
            15:      root = 64'd5623413251903;
            16:      root = 64'd6309573444802;
            17:      root = 64'd7079457843841;
            18:      root = 64'd7943282347243;
            default: root = 64'd8912509381337;
         endcase
         num = root * 64'd65536;
         case (q)
            0:       quo = (num + 64'd500000000000) / 64'd1000000000000;
            1:       quo = (num + 64'd50000000000) / 64'd100000000000;
            2:       quo = (num + 64'd5000000000) / 64'd10000000000;
            3:       quo = (num + 64'd500000000) / 64'd1000000000;
            default: quo = (num + 64'd50000000) / 64'd100000000;
         endcase
         tab[k] = quo[THR_W-1:0];
      end
      return tab;
   endfunction

   localparam thr_tab_type THR_TAB = build_thr_tab();

endpackage

`default_nettype wire

// ----- hdl/audio_frame_level_db.sv -----
// Top level of the frame level meter in whole decibels.
//
// Input stream (req_): one signed 16-bit audio sample per transaction in
// req_tdata, with req_tlast marking the last sample of a frame. Samples are
// taken one per cycle while the two-entry frame queue has room.
// Output stream (rsp_): one transaction per frame, the signed level in dB,
// trunc(20*log10(sum/count)), or 0 for a silent frame. At most 4096 samples
// of a frame are counted; later ones only end the frame.
// Level search: a binary search over 97 thresholds in up to seven steps,
// each a multiply state and then a compare state on one 13x33 multiplier.
// Throughput: one sample per cycle; frames shorter than the search time
// fill the queue and then hold off req_tready until the search catches up.
// Reset (synchronous, active high) clears the running sum, the count, the
// queue and any pending result. A stalled receiver keeps the result in the
// output register; the next search runs meanwhile and waits to deliver.
`default_nettype none

module audio_frame_level_db (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,    // [15:0] sample
   input  wire         req_tlast,    // last_sample
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata     // [7:0] level_db
);
   import afld_pkg::*;

   logic      push_valid;
   frame_type push_data;
   logic      queue_full;
   logic      queue_empty;
   logic      queue_pop;
   frame_type queue_data;

   // Accumulation of each frame.
   afld_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   // Finished frame totals wait here for the level search.
   afld_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (queue_pop),
      .pop_data   (queue_data),
      .empty      (queue_empty)
   );

   // Conversion of frame totals to a dB level.
   afld_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_data  (queue_data),
      .queue_pop   (queue_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

`default_nettype wire

// ----- hdl/afld_front.sv -----
// Sample accumulator: sums absolute sample values and counts them per frame.
`default_nettype none

module afld_front (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   input  wire  [15:0]            req_tdata,   // [15:0] sample
   input  wire                    req_tlast,   // last_sample
   input  wire                    queue_full,
   output logic                   push_valid,
   output afld_pkg::frame_type    push_data
);
   import afld_pkg::*;

   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0] sum_next;
   logic [CNT_W-1:0] cnt_next;
   logic [MAG_W-1:0] mag;
   logic             accepted;

   // A transaction is taken whenever the queue has room for a finished frame.
   assign req_tready = !queue_full;
   assign accepted   = req_tvalid && req_tready;

   // Magnitude of the sample; the most negative value maps to 32768.
   always_comb begin
      if (req_tdata[15]) begin
         mag = MAG_W'(17'h10000 - {1'b0, req_tdata});
      end else begin
         mag = {1'b0, req_tdata};
      end
   end

   // Samples beyond the frame limit are neither added nor counted.
   always_comb begin
      if (cnt_ff < CNT_W'(MAX_SAMPLES)) begin
         sum_next = sum_ff + SUM_W'(mag);
         cnt_next = cnt_ff + CNT_W'(1);
      end else begin
         sum_next = sum_ff;
         cnt_next = cnt_ff;
      end
   end

   // The last sample hands the totals to the queue and restarts the frame.
   always_comb begin
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      if (accepted) begin
         if (req_tlast) begin
            sum_in = '0;
            cnt_in = '0;
         end else begin
            sum_in = sum_next;
            cnt_in = cnt_next;
         end
      end
   end

   assign push_valid             = accepted && req_tlast;
   assign push_data.abs_sum      = sum_next;
   assign push_data.sample_count = cnt_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         cnt_ff <= '0;
      end else begin
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/afld_queue.sv -----
// Two-entry queue of finished frame totals between the accumulator and the level search.
`default_nettype none

module afld_queue (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push_valid,
   input  afld_pkg::frame_type    push_data,
   output logic                   full,
   input  wire                    pop,
   output afld_pkg::frame_type    pop_data,
   output logic                   empty
);
   import afld_pkg::*;

   frame_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QFILL_W-1:0] fill_ff, fill_in;
   logic               do_push;
   logic               do_pop;

   assign full     = (fill_ff == QFILL_W'(QUEUE_DEPTH));
   assign empty    = (fill_ff == '0);
   assign do_push  = push_valid && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + QFILL_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - QFILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/afld_back.sv -----
// Level search: binary search over the dB threshold table with one shared multiplier.
`default_nettype none

module afld_back (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    queue_empty,
   input  afld_pkg::frame_type    queue_data,
   output logic                   queue_pop,
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   output logic [7:0]             rsp_tdata    // [7:0] level_db
);
   import afld_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_CMP  = 4'b0100,
      ST_DONE = 4'b1000
   } back_state_type;

   back_state_type     state_ff, state_in;
   logic               out_valid_ff, out_valid_in;
   logic [LEVEL_W-1:0] out_level_ff, out_level_in;
   logic [STEP_W-1:0]  lo_ff, lo_in;
   logic [STEP_W-1:0]  hi_ff, hi_in;
   logic [STEP_W-1:0]  mid_ff, mid_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               pos_ff, pos_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;

   logic [STEP_W:0]    mid_sum;
   logic [STEP_W-1:0]  mid;
   logic [CNT_W-1:0]   mul_a;
   logic [PROD_W-1:0]  lhs_pos;
   logic [PROD_W-1:0]  rhs_neg;
   logic               pass;
   logic               out_free;

   // Midpoint rounded up, so the search always makes progress.
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff} + (STEP_W+1)'(1);
   assign mid     = mid_sum[STEP_W:1];

   // At or above 0 dB the count is scaled, below it the sum (which is then under the count).
   // The product for the new midpoint is registered together with the midpoint itself.
   assign mul_a   = pos_ff ? cnt_ff : sum_ff[CNT_W-1:0];
   assign prod_in = PROD_W'(mul_a) * PROD_W'(THR_TAB[mid]);

   // Threshold test on the registered product.
   assign lhs_pos = PROD_W'({sum_ff, {FRAC_W{1'b0}}});
   assign rhs_neg = PROD_W'({cnt_ff, {FRAC_W{1'b0}}});
   assign pass    = pos_ff ? (lhs_pos >= prod_ff) : (prod_ff <= rhs_neg);

   assign out_free = !out_valid_ff || rsp_tready;

   // Search sequencer and output register.
   always_comb begin
      state_in     = state_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      queue_pop    = 1'b0;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_level_in = out_level_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               queue_pop = 1'b1;
               sum_in    = queue_data.abs_sum;
               cnt_in    = queue_data.sample_count;
               pos_in    = (queue_data.abs_sum >= SUM_W'(queue_data.sample_count));
               lo_in     = '0;
               // A zero sum or an empty count gives a level of zero.
               if ((queue_data.abs_sum == '0) || (queue_data.sample_count == '0)) begin
                  hi_in    = '0;
                  state_in = ST_DONE;
               end else begin
                  hi_in    = STEP_W'(TOP_STEP);
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            mid_in   = mid;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (pass) begin
               lo_in = mid_ff;
            end else begin
               hi_in = mid_ff - STEP_W'(1);
            end
            if ((pass ? mid_ff : lo_ff) == (pass ? hi_ff : mid_ff - STEP_W'(1))) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_level_in = pos_ff ? {1'b0, lo_ff}
                                     : LEVEL_W'(LEVEL_W'(0) - {1'b0, lo_ff});
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Search operands and result payload.
   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      sum_ff       <= sum_in;
      cnt_ff       <= cnt_in;
      pos_ff       <= pos_in;
      prod_ff      <= prod_in;
      out_level_ff <= out_level_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_level_ff;

endmodule

`default_nettype wire
